>>> rtl/cdecc_pkg.sv
// Shared types, constants and Galois-field helpers for the CD-ROM sector repair block.
// Used by every other module in rtl/ except cdecc_ram; depends on nothing else.
`timescale 1ns / 1ps

package cdecc_pkg;

	localparam int SECTOR_BYTES = 2352;
	localparam int SYNC_END     = 12;
	localparam int HDR_END      = 16;
	localparam int EDC_POS      = 2072;
	localparam int P_POS        = 2076;
	localparam int Q_POS        = 2248;
	localparam int P_COUNT      = 86;
	localparam int Q_COUNT      = 52;
	localparam int Q_COLS       = 43;
	localparam int Q_DIAGS      = 26;
	localparam int P_EXP_START  = 25;
	localparam int Q_EXP_START  = 44;
	localparam int COEF_COUNT   = 45;
	localparam int PAR_W        = 16;

	localparam int POS_W  = 12;
	localparam int PA_W   = $clog2(P_COUNT);
	localparam int QA_W   = $clog2(Q_COUNT);
	localparam int EXP_W  = $clog2(COEF_COUNT);
	localparam int PEXP_W = $clog2(P_EXP_START + 1);
	localparam int COL_W  = $clog2(Q_COLS);
	localparam int DIAG_W = $clog2(Q_DIAGS);

	localparam logic [7:0]  MODE_TWO  = 8'd2;
	localparam int          FORM2_BIT = 21;  // bit 5 of submode byte 18 in the subheader word
	localparam logic [31:0] EDC_POLY  = 32'hD801_8001;
	localparam logic [8:0]  GF_POLY   = 9'h11D;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_MODE2 = 2'd1,
		ST_FORM2     = 2'd2
	} status_t;

	// One classified byte as it travels from the front end to the back end.
	typedef struct packed {
		logic [7:0]        data;
		logic [POS_W-1:0]  pos;
		logic [PA_W-1:0]   p_addr;
		logic [PEXP_W-1:0] p_exp;
		logic              p_first;
		logic [QA_W-1:0]   q_addr;
		logic [EXP_W-1:0]  q_exp;
		logic              q_first;
		logic              last;
		status_t           status;
		logic              mismatch;
	} item_t;

	function automatic logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
		logic [8:0] x;
		logic [7:0] r;
		x = {1'b0, a};
		r = '0;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) begin
				r = r ^ x[7:0];
			end
			x = {x[7:0], 1'b0};
			if (x[8]) begin
				x = x ^ GF_POLY;
			end
		end
		return r;
	endfunction

	// Parity coefficient (alpha^e + 1) / 3 for each check-row weight.
	function automatic logic [COEF_COUNT-1:0][7:0] coef_table();
		logic [7:0] inv3;
		logic [7:0] pw;
		logic [COEF_COUNT-1:0][7:0] tab;
		inv3 = 8'd1;
		for (int i = 0; i < 254; i++) begin
			inv3 = gf_mul(inv3, 8'd3);
		end
		pw = 8'd1;
		for (int e = 0; e < COEF_COUNT; e++) begin
			tab[e] = gf_mul(pw ^ 8'd1, inv3);
			pw = gf_mul(pw, 8'd2);
		end
		return tab;
	endfunction

	function automatic logic [31:0] edc_step(logic [31:0] acc, logic [7:0] b);
		logic [31:0] c;
		c = acc ^ {24'd0, b};
		for (int i = 0; i < 8; i++) begin
			c = (c >> 1) ^ (c[0] ? EDC_POLY : 32'd0);
		end
		return c;
	endfunction

endpackage

>>> rtl/cdecc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; used for the P and Q parity accumulators.
`timescale 1ns / 1ps

module cdecc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> rtl/cdecc_front.sv
// Front end: tracks the byte position, classifies each byte and checks the header.
// Depends on cdecc_pkg; feeds cdecc_fifo.
`timescale 1ns / 1ps

module cdecc_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  logic [7:0]           in_byte,
	input  logic                 sector_start,
	output cdecc_pkg::item_t     item
);

	logic [cdecc_pkg::POS_W-1:0]  pos_q, pos_eff;
	logic [7:0]                   mode_q;
	logic [31:0]                  sub_q;
	logic                         mism_q;
	logic [cdecc_pkg::PA_W-1:0]   pidx_q;
	logic [cdecc_pkg::PEXP_W-1:0] pexp_q;
	logic                         prow0_q;
	logic [cdecc_pkg::COL_W-1:0]  col_q;
	logic                         half_q;
	logic [cdecc_pkg::DIAG_W-1:0] diag_q;
	logic [cdecc_pkg::EXP_W-1:0]  qexp_q;
	logic                         qrow0_q;
	logic [cdecc_pkg::QA_W-1:0]   qo_q;
	logic                         pre_data;
	logic [1:0]                   lane;

	assign pos_eff  = (sector_start || pos_q >= cdecc_pkg::SECTOR_BYTES) ? '0 : pos_q;
	assign pre_data = pos_eff < cdecc_pkg::SYNC_END;
	assign lane     = pos_eff[1:0];

	always_comb begin
		item          = '0;
		item.data     = in_byte;
		item.pos      = pos_eff;
		item.p_addr   = pidx_q;
		item.p_exp    = pexp_q;
		item.p_first  = prow0_q;
		item.q_addr   = (pos_eff >= cdecc_pkg::Q_POS) ? qo_q : {diag_q, half_q};
		item.q_exp    = qexp_q;
		item.q_first  = qrow0_q && (col_q < cdecc_pkg::Q_DIAGS);
		item.last     = pos_eff == cdecc_pkg::SECTOR_BYTES - 1;
		item.status   = cdecc_pkg::ST_OK;
		item.mismatch = 1'b0;
		if (item.last) begin
			item.mismatch = mism_q;
			if (mode_q != cdecc_pkg::MODE_TWO) begin
				item.status = cdecc_pkg::ST_NOT_MODE2;
			end else if (sub_q[cdecc_pkg::FORM2_BIT]) begin
				item.status = cdecc_pkg::ST_FORM2;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			mode_q  <= '0;
			sub_q   <= '0;
			mism_q  <= 1'b0;
			pidx_q  <= '0;
			pexp_q  <= cdecc_pkg::PEXP_W'(cdecc_pkg::P_EXP_START);
			prow0_q <= 1'b1;
			col_q   <= '0;
			half_q  <= 1'b0;
			diag_q  <= '0;
			qexp_q  <= cdecc_pkg::EXP_W'(cdecc_pkg::Q_EXP_START);
			qrow0_q <= 1'b1;
			qo_q    <= '0;
		end else if (accept) begin
			pos_q <= pos_eff + 1'b1;
			if (pos_eff == '0) begin
				mode_q <= '0;
				sub_q  <= '0;
				mism_q <= 1'b0;
			end
			if (pos_eff == cdecc_pkg::HDR_END - 1) begin
				mode_q <= in_byte;
			end
			if (pos_eff >= cdecc_pkg::HDR_END && pos_eff < cdecc_pkg::HDR_END + 4) begin
				sub_q[8*lane +: 8] <= in_byte;
			end
			if (pos_eff >= cdecc_pkg::HDR_END + 4 && pos_eff < cdecc_pkg::HDR_END + 8) begin
				if (sub_q[8*lane +: 8] != in_byte) begin
					mism_q <= 1'b1;
				end
			end
			// Position counters: the first data byte after the sync starts them all over.
			if (pre_data) begin
				pidx_q  <= '0;
				pexp_q  <= cdecc_pkg::PEXP_W'(cdecc_pkg::P_EXP_START);
				prow0_q <= 1'b1;
				col_q   <= '0;
				half_q  <= 1'b0;
				diag_q  <= '0;
				qexp_q  <= cdecc_pkg::EXP_W'(cdecc_pkg::Q_EXP_START);
				qrow0_q <= 1'b1;
			end else begin
				if (pidx_q == cdecc_pkg::PA_W'(cdecc_pkg::P_COUNT - 1)) begin
					pidx_q  <= '0;
					pexp_q  <= pexp_q - 1'b1;
					prow0_q <= 1'b0;
				end else begin
					pidx_q <= pidx_q + 1'b1;
				end
				half_q <= ~half_q;
				if (half_q) begin
					if (col_q == cdecc_pkg::COL_W'(cdecc_pkg::Q_COLS - 1)) begin
						col_q   <= '0;
						qexp_q  <= cdecc_pkg::EXP_W'(cdecc_pkg::Q_EXP_START);
						qrow0_q <= 1'b0;
						// Next row: diagonal moves by 43 mod 26.
						diag_q  <= (diag_q >= cdecc_pkg::DIAG_W'(cdecc_pkg::Q_DIAGS - 17)) ?
							diag_q - cdecc_pkg::DIAG_W'(cdecc_pkg::Q_DIAGS - 17) :
							diag_q + 5'd17;
					end else begin
						col_q  <= col_q + 1'b1;
						qexp_q <= qexp_q - 1'b1;
						diag_q <= (diag_q == '0) ?
							cdecc_pkg::DIAG_W'(cdecc_pkg::Q_DIAGS - 1) : diag_q - 1'b1;
					end
				end
			end
			if (pre_data || pos_eff == cdecc_pkg::Q_POS - 1 ||
			    qo_q == cdecc_pkg::QA_W'(cdecc_pkg::Q_COUNT - 1)) begin
				qo_q <= '0;
			end else begin
				qo_q <= qo_q + 1'b1;
			end
		end
	end

endmodule

>>> rtl/cdecc_fifo.sv
// Two-entry queue of classified bytes between front end and back end.
// Depends on cdecc_pkg for the entry type.
`timescale 1ns / 1ps

module cdecc_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  cdecc_pkg::item_t wr_item,
	output logic             full,
	input  logic             pop,
	output logic             head_valid,
	output cdecc_pkg::item_t head
);

	cdecc_pkg::item_t ent_q [2];
	logic [1:0]       cnt_q;
	logic             rd_q, wr_q;

	assign full       = cnt_q == 2'd2;
	assign head_valid = cnt_q != 2'd0;
	assign head       = ent_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			rd_q  <= 1'b0;
			wr_q  <= 1'b0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

>>> rtl/cdecc_back.sv
// Back end: rewrites sync, folds the EDC, updates P and Q parity in RAM and
// drives the output register. Depends on cdecc_pkg and cdecc_ram.
`timescale 1ns / 1ps

module cdecc_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             head_valid,
	input  cdecc_pkg::item_t head,
	output logic             pop,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [7:0]       m_tdata,
	output logic             m_tlast,
	output logic [2:0]       m_tuser
);

	localparam logic [cdecc_pkg::COEF_COUNT-1:0][7:0] CoefTab = cdecc_pkg::coef_table();

	cdecc_pkg::item_t             it_s1;
	logic                         v_s1;
	logic                         adv, load;
	logic [31:0]                  edc_q;
	logic [cdecc_pkg::PAR_W-1:0]  p_rd, q_rd, p_new, q_new;
	logic [cdecc_pkg::PA_W-1:0]   p_raddr;
	logic [cdecc_pkg::QA_W-1:0]   q_raddr;
	logic [7:0]                   o, fv, pc, qc, p0, q0;
	logic                         p_upd, q_upd;
	logic [cdecc_pkg::POS_W-1:0]  pos;
	logic                         m_tvalid_q;
	logic [7:0]                   m_tdata_q;
	logic                         m_tlast_q;
	logic [2:0]                   m_tuser_q;

	assign adv  = v_s1 && (!m_tvalid_q || m_tready);
	assign load = head_valid && (!v_s1 || adv);
	assign pop  = load;

	// The RAMs look up the address of whatever sits in the stage on the next edge.
	assign p_raddr = load ? head.p_addr : it_s1.p_addr;
	assign q_raddr = load ? head.q_addr : it_s1.q_addr;

	cdecc_ram #(.WIDTH(cdecc_pkg::PAR_W), .DEPTH(cdecc_pkg::P_COUNT)) u_pram (
		.clk   (clk),
		.we    (adv && p_upd),
		.waddr (it_s1.p_addr),
		.wdata (p_new),
		.raddr (p_raddr),
		.rdata (p_rd)
	);

	cdecc_ram #(.WIDTH(cdecc_pkg::PAR_W), .DEPTH(cdecc_pkg::Q_COUNT)) u_qram (
		.clk   (clk),
		.we    (adv && q_upd),
		.waddr (it_s1.q_addr),
		.wdata (q_new),
		.raddr (q_raddr),
		.rdata (q_rd)
	);

	assign pos = it_s1.pos;

	always_comb begin
		if (pos < cdecc_pkg::SYNC_END) begin
			o = (pos == '0 || pos == cdecc_pkg::POS_W'(cdecc_pkg::SYNC_END - 1)) ? 8'h00 : 8'hFF;
		end else if (pos < cdecc_pkg::EDC_POS) begin
			o = it_s1.data;
		end else if (pos < cdecc_pkg::P_POS) begin
			o = edc_q[8*pos[1:0] +: 8];
		end else if (pos < cdecc_pkg::P_POS + cdecc_pkg::P_COUNT) begin
			o = p_rd[15:8];
		end else if (pos < cdecc_pkg::Q_POS) begin
			o = p_rd[7:0];
		end else if (pos < cdecc_pkg::Q_POS + cdecc_pkg::Q_COUNT) begin
			o = q_rd[15:8];
		end else begin
			o = q_rd[7:0];
		end
	end

	// Header bytes count as zero in both parities.
	assign fv    = (pos < cdecc_pkg::HDR_END) ? 8'h00 : o;
	assign p_upd = pos >= cdecc_pkg::SYNC_END && pos < cdecc_pkg::P_POS;
	assign q_upd = pos >= cdecc_pkg::SYNC_END && pos < cdecc_pkg::Q_POS;
	assign pc    = CoefTab[{1'b0, it_s1.p_exp}];
	assign qc    = CoefTab[it_s1.q_exp];
	assign p0    = cdecc_pkg::gf_mul(fv, pc);
	assign q0    = cdecc_pkg::gf_mul(fv, qc);
	assign p_new = (it_s1.p_first ? '0 : p_rd) ^ {p0, fv ^ p0};
	assign q_new = (it_s1.q_first ? '0 : q_rd) ^ {q0, fv ^ q0};

	always_ff @(posedge clk) begin
		if (load) begin
			it_s1 <= head;
		end
		if (adv) begin
			m_tdata_q <= o;
			m_tlast_q <= it_s1.last;
			m_tuser_q <= {it_s1.mismatch, it_s1.status};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1       <= 1'b0;
			m_tvalid_q <= 1'b0;
			edc_q      <= '0;
		end else begin
			if (load) begin
				v_s1 <= 1'b1;
			end else if (adv) begin
				v_s1 <= 1'b0;
			end
			if (adv) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (adv && pos >= cdecc_pkg::HDR_END && pos < cdecc_pkg::EDC_POS) begin
				edc_q <= cdecc_pkg::edc_step((pos == cdecc_pkg::HDR_END) ? '0 : edc_q,
					it_s1.data);
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;
	assign m_tuser  = m_tuser_q;

endmodule

>>> rtl/cdrom_mode2_form1_edc_ecc.sv
// Path: an accepted byte passes the queue, the back end stage register and the output register.
// Throughput: one byte per cycle sustained while m_tready is high; m_tready low stalls the output.
// Reset: arst_n clears the position, header checks, queue and output valid at once.
// The parity RAMs need no clearing pass: the first touch of each entry in a sector overwrites it.
`timescale 1ns / 1ps

// Top level of the CD-ROM mode 2 form 1 sector repair block.
// Depends on cdecc_pkg, cdecc_front, cdecc_fifo and cdecc_back.
//
// Raw sector bytes enter on the slave stream one word at a time. The front
// end derives each byte's position within the sector (restarting on tuser or
// after byte 2351), keeps the mode byte and first subheader copy, and works
// out which P and Q accumulators the byte feeds and with what weight. A two
// word queue decouples it from the back end, which rewrites the sync field,
// folds bytes 16..2071 into the EDC, accumulates RSPC parity in two small
// RAMs and emits the repaired word through a registered output.
module cdrom_mode2_form1_edc_ecc (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] in_byte
	input  logic [0:0] s_tuser,   // [0] sector_start
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] out_byte
	output logic       m_tlast,   // sector_end
	output logic [2:0] m_tuser    // [1:0] status, [2] subheader_mismatch
);

	cdecc_pkg::item_t front_item;
	cdecc_pkg::item_t head;
	logic             full, head_valid, pop, accept;

	// A word is taken whenever the queue has room.
	assign s_tready = !full;
	assign accept   = s_tvalid && s_tready;

	cdecc_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.in_byte      (s_tdata),
		.sector_start (s_tuser[0]),
		.item         (front_item)
	);

	cdecc_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (accept),
		.wr_item    (front_item),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	// The back end presents status and mismatch only on the last word of a sector.
	cdecc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast),
		.m_tuser    (m_tuser)
	);

endmodule

>>> rtl/cdecc_checker.sv
// Port-level checks on the master side of the sector repair block.
// Depends on cdecc_pkg; bound to cdrom_mode2_form1_edc_ecc.
`timescale 1ns / 1ps

module cdecc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic       m_tlast,
	input logic [2:0] m_tuser
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
			&& $stable(m_tuser))
		else $error("output word changed while stalled");

	a_flags_only_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> m_tuser == 3'd0)
		else $error("status or mismatch flag set away from sector end");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tuser[1:0] == cdecc_pkg::ST_OK || m_tuser[1:0] == cdecc_pkg::ST_NOT_MODE2
			|| m_tuser[1:0] == cdecc_pkg::ST_FORM2)
		else $error("undefined status code");

endmodule

bind cdrom_mode2_form1_edc_ecc cdecc_checker u_cdecc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast),
	.m_tuser  (m_tuser)
);

>>> tb/tb_cdrom_mode2_form1_edc_ecc.sv
// Self-checking testbench for the CD-ROM mode 2 form 1 sector repair block.
// Depends on rtl/cdecc_pkg.sv and rtl/cdrom_mode2_form1_edc_ecc.sv only.
// A cycle-free software copy of the repair predicts every output word.
`timescale 1ns / 1ps

module tb_cdrom_mode2_form1_edc_ecc;
	import cdecc_pkg::*;

	localparam int STALL_LIMIT = 3000;
	localparam int HOLD_CYCLES = 400;

	logic       clk;
	logic       arst_n;
	logic       s_tvalid;
	logic       s_tready;
	logic [7:0] s_tdata;
	logic [0:0] s_tuser;
	logic       m_tvalid;
	logic       m_tready;
	logic [7:0] m_tdata;
	logic       m_tlast;
	logic [2:0] m_tuser;

	cdrom_mode2_form1_edc_ecc DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.m_tuser(m_tuser)
	);

	// One repaired output word as the predictor expects it.
	typedef struct {
		logic [7:0] data;
		logic       last;
		status_t    status;
		logic       mismatch;
	} repaired_t;

	// One row of the directed table; known marks a typed-in expected byte.
	typedef struct {
		logic [7:0] data;
		logic       start;
		logic       known;
		logic [7:0] want;
	} row_t;

	repaired_t repaired_q[$];

	// Predictor copy of the sector state.
	int          cur_pos;
	logic [31:0] crc_acc;
	logic [15:0] p_acc [P_COUNT];
	logic [15:0] q_acc [Q_COUNT];
	logic [7:0]  hdr_mode;
	logic [31:0] sub_copy;
	logic        sub_differs;
	logic [7:0]  rspc_coef [COEF_COUNT];

	int  errors;
	int  words_in;
	int  words_out;
	int  sectors_done;
	bit  quiet;
	bit  hold_req;
	bit  stim_done;

	function automatic logic [7:0] field_mul(logic [7:0] a, logic [7:0] b);
		logic [8:0] sh;
		logic [7:0] acc;
		sh = {1'b0, a};
		acc = 8'h00;
		for (int i = 0; i < 8; i++) begin
			if (b[i])
				acc ^= sh[7:0];
			sh = sh << 1;
			if (sh[8])
				sh ^= 9'h11D;
		end
		return acc;
	endfunction

	// Coefficient (alpha^e + 1) * 3^-1; 3^254 is the inverse of 3.
	task automatic build_coefs();
		logic [7:0] inv3;
		logic [7:0] apow;
		inv3 = 8'h01;
		for (int i = 0; i < 254; i++)
			inv3 = field_mul(inv3, 8'h03);
		apow = 8'h01;
		for (int e = 0; e < COEF_COUNT; e++) begin
			rspc_coef[e] = field_mul(apow ^ 8'h01, inv3);
			apow = field_mul(apow, 8'h02);
		end
	endtask

	function automatic logic [15:0] parity_pair(logic [7:0] d, int e);
		logic [7:0] hi;
		hi = field_mul(d, rspc_coef[e]);
		return {hi, d ^ hi};
	endfunction

	function automatic void clear_sector_state();
		cur_pos = 0;
		crc_acc = '0;
		hdr_mode = '0;
		sub_copy = '0;
		sub_differs = 1'b0;
		for (int i = 0; i < P_COUNT; i++)
			p_acc[i] = '0;
		for (int i = 0; i < Q_COUNT; i++)
			q_acc[i] = '0;
	endfunction

	// Advances the predictor by one accepted input word and returns the repaired word.
	function automatic repaired_t repair_word(logic [7:0] b, logic start);
		repaired_t res;
		logic [7:0] o;
		logic [7:0] fv;
		int pos, r, w, col, diag;
		if (start || cur_pos >= SECTOR_BYTES)
			clear_sector_state();
		pos = cur_pos;
		if (pos < SYNC_END) begin
			o = (pos == 0 || pos == SYNC_END - 1) ? 8'h00 : 8'hFF;
		end else if (pos < EDC_POS) begin
			o = b;
			if (pos == HDR_END - 1)
				hdr_mode = b;
			if (pos >= HDR_END) begin
				crc_acc ^= {24'd0, b};
				for (int i = 0; i < 8; i++)
					crc_acc = (crc_acc >> 1) ^ (crc_acc[0] ? 32'hD801_8001 : 32'd0);
			end
			if (pos >= HDR_END && pos < HDR_END + 4)
				sub_copy |= {24'd0, b} << (8 * (pos - HDR_END));
			if (pos >= HDR_END + 4 && pos < HDR_END + 8)
				if (sub_copy[8 * (pos - HDR_END - 4) +: 8] != b)
					sub_differs = 1'b1;
		end else if (pos < P_POS) begin
			o = crc_acc[8 * (pos - EDC_POS) +: 8];
		end else if (pos < P_POS + P_COUNT) begin
			o = p_acc[pos - P_POS][15:8];
		end else if (pos < Q_POS) begin
			o = p_acc[pos - P_POS - P_COUNT][7:0];
		end else if (pos < Q_POS + Q_COUNT) begin
			o = q_acc[pos - Q_POS][15:8];
		end else begin
			o = q_acc[(pos - Q_POS - Q_COUNT) % Q_COUNT][7:0];
		end

		// The header is taken as zero; the EDC and P bytes feed Q as written.
		if (pos >= SYNC_END && pos < Q_POS) begin
			fv = (pos < HDR_END) ? 8'h00 : o;
			r = pos - SYNC_END;
			if (r < 24 * P_COUNT)
				p_acc[r % P_COUNT] ^= parity_pair(fv, 25 - r / P_COUNT);
			w = r >> 1;
			col = w % Q_COLS;
			diag = (w / Q_COLS + 2 * Q_DIAGS - col) % Q_DIAGS;
			q_acc[(2 * diag + (r & 1)) % Q_COUNT] ^= parity_pair(fv, 44 - col);
		end

		res.data = o;
		res.last = 1'b0;
		res.status = ST_OK;
		res.mismatch = 1'b0;
		if (pos == SECTOR_BYTES - 1) begin
			res.last = 1'b1;
			if (hdr_mode != MODE_TWO)
				res.status = ST_NOT_MODE2;
			else if (sub_copy[FORM2_BIT])
				res.status = ST_FORM2;
			res.mismatch = sub_differs;
		end
		cur_pos = (pos + 1) & 12'hFFF;
		return res;
	endfunction

	// Clock and the single reset at the start of the run.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Offers one word and returns once it has been accepted; a random gap may come first.
	task automatic send_word(logic [7:0] b, logic start, logic known, logic [7:0] want);
		repaired_t exp_w;
		if (!quiet && $urandom_range(0, 9) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tuser  <= start;
		do @(posedge clk); while (!s_tready);
		exp_w = repair_word(b, start);
		if (known)
			exp_w.data = want;
		repaired_q.push_back(exp_w);
		words_in++;
	endtask

	// Sends one sector of len words. The sector is well formed apart from the
	// mode byte, the form bit and the subheader copy, chosen by the caller.
	task automatic send_sector(logic start, logic [7:0] mode, bit form2, bit differ, int len,
			int hold_at);
		logic [7:0] sub [4];
		logic [7:0] b;
		int bad_idx;
		for (int i = 0; i < 4; i++)
			sub[i] = $urandom_range(0, 255);
		sub[2][5] = form2;
		bad_idx = $urandom_range(0, 3);
		for (int pos = 0; pos < len; pos++) begin
			b = $urandom_range(0, 255);
			if (pos == HDR_END - 1)
				b = mode;
			else if (pos >= HDR_END && pos < HDR_END + 4)
				b = sub[pos - HDR_END];
			else if (pos >= HDR_END + 4 && pos < HDR_END + 8)
				b = (differ && pos - HDR_END - 4 == bad_idx) ? ~sub[pos - HDR_END - 4]
					: sub[pos - HDR_END - 4];
			if (pos == hold_at)
				hold_req = 1'b1;
			send_word(b, start && pos == 0, 1'b0, 8'h00);
		end
	endtask

	// Directed rows: sync rewrite on extreme bytes, a restart in mid-sector,
	// and a header of extremes that the predictor follows into the subheader.
	row_t dir_rows[] = '{
		'{8'hFF, 1'b1, 1'b1, 8'h00}, '{8'h00, 1'b0, 1'b1, 8'hFF},
		'{8'h5A, 1'b0, 1'b1, 8'hFF}, '{8'hA5, 1'b1, 1'b1, 8'h00},
		'{8'h00, 1'b0, 1'b1, 8'hFF}, '{8'hFF, 1'b0, 1'b1, 8'hFF},
		'{8'h00, 1'b0, 1'b1, 8'hFF}, '{8'hFF, 1'b0, 1'b1, 8'hFF},
		'{8'h00, 1'b0, 1'b1, 8'hFF}, '{8'hFF, 1'b0, 1'b1, 8'hFF},
		'{8'h00, 1'b0, 1'b1, 8'hFF}, '{8'hFF, 1'b0, 1'b1, 8'hFF},
		'{8'h00, 1'b0, 1'b1, 8'hFF}, '{8'hFF, 1'b0, 1'b1, 8'hFF},
		'{8'h12, 1'b0, 1'b1, 8'h00}, '{8'hFF, 1'b0, 1'b1, 8'hFF},
		'{8'h00, 1'b0, 1'b1, 8'h00}, '{8'hFF, 1'b0, 1'b1, 8'hFF},
		'{8'h02, 1'b0, 1'b0, 8'h00}, '{8'hFF, 1'b0, 1'b0, 8'h00},
		'{8'h00, 1'b0, 1'b0, 8'h00}, '{8'h80, 1'b0, 1'b0, 8'h00},
		'{8'h01, 1'b0, 1'b0, 8'h00}, '{8'hFF, 1'b0, 1'b0, 8'h00}
	};

	// Stimulus: directed table, then one full form 2 sector with a subheader
	// mismatch and a long receiver hold-off, then random bytes that run on past
	// its end without a start flag.
	initial begin
		s_tvalid = 1'b0;
		s_tdata  = 8'h00;
		s_tuser  = 1'b0;
		quiet = 1'b0;
		hold_req = 1'b0;
		stim_done = 1'b0;
		errors = 0;
		words_in = 0;
		words_out = 0;
		sectors_done = 0;
		build_coefs();
		clear_sector_state();
		wait (arst_n === 1'b1);
		@(posedge clk);
		foreach (dir_rows[i])
			send_word(dir_rows[i].data, dir_rows[i].start, dir_rows[i].known, dir_rows[i].want);

		send_sector(1'b1, MODE_TWO, 1'b1, 1'b1, SECTOR_BYTES, 700);
		// The next sector starts without the flag, right after byte 2351.
		quiet = 1'b1;
		for (int k = 0; k < 100; k++)
			send_word($urandom_range(0, 255), 1'b0, 1'b0, 8'h00);
		s_tvalid <= 1'b0;
		stim_done = 1'b1;
	end

	// Receiver: random stall bursts, one long hold-off on request, none at the end.
	initial begin
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			if (!quiet && $urandom_range(0, 7) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 5) - 1) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Compares each accepted output word with the oldest expectation.
	always @(posedge clk) begin
		repaired_t exp_w;
		if (arst_n && m_tvalid && m_tready) begin
			words_out++;
			if (m_tlast)
				sectors_done++;
			if (repaired_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected output word %02h", m_tdata);
			end else begin
				exp_w = repaired_q.pop_front();
				if (m_tdata !== exp_w.data || m_tlast !== exp_w.last ||
						m_tuser[1:0] !== exp_w.status || m_tuser[2] !== exp_w.mismatch) begin
					errors++;
					if (errors <= 10)
						$display("word %0d: expected data %02h last %b status %0d mism %b, got %02h %b %0d %b",
							words_out, exp_w.data, exp_w.last, exp_w.status, exp_w.mismatch,
							m_tdata, m_tlast, m_tuser[1:0], m_tuser[2]);
				end
			end
		end
	end

	// Watchdog and end of run.
	initial begin
		int idle;
		bit timed_out;
		idle = 0;
		timed_out = 1'b0;
		while (!(stim_done && repaired_q.size() == 0) && !timed_out) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle = 0;
			else
				idle++;
			timed_out = idle >= STALL_LIMIT;
		end
		if (!timed_out)
			repeat (20) @(posedge clk);
		if (repaired_q.size() != 0) begin
			errors += repaired_q.size();
			$display("%0d expected words never arrived", repaired_q.size());
		end
		$display("Sent %0d bytes, checked %0d words over %0d complete sectors.",
			words_in, words_out, sectors_done);
		$display("Covered sync rewrite, a mid-sector restart, a full form 2 sector with a bad subheader copy and a run-on.");
		if (timed_out)
			$display("tb_cdrom_mode2_form1_edc_ecc: FAIL");
		else if (errors == 0)
			$display("tb_cdrom_mode2_form1_edc_ecc: PASS");
		else
			$display("tb_cdrom_mode2_form1_edc_ecc: FAIL");
		$finish;
	end

endmodule
